/* hdl/cpcr_pkg.sv */
// Shared widths and stage map for the circle pair collision response pipeline.
package cpcr_pkg;

	// coordinate format
	localparam int COORD_W   = 24;
	localparam int FRAC_BITS = 8;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

	// pipelined restoring divider
	localparam int DIV_NUM_W = 36;
	localparam int DIV_DEN_W = 17;
	localparam int DIV_QUO_W = 18;

	// pipelined integer square root
	localparam int SQ_IN_W   = 34;
	localparam int SQ_ROOT_W = 17;
	localparam int SQ_REM_W  = 36;

	// pipeline map: register stage index where each unit is fed
	localparam int PIPE_DEPTH  = 60;
	localparam int ST_SQRT_IN  = 3;
	localparam int ST_NDIV_IN  = ST_SQRT_IN + SQ_ROOT_W + 1;
	localparam int ST_NRM      = ST_NDIV_IN + DIV_QUO_W + 1;
	localparam int ST_MR_IN    = ST_NRM + 2 - DIV_QUO_W;
	localparam int ST_MDIV_IN  = ST_NRM + 1;

endpackage

/* hdl/cpcr_isqrt.sv */
// Pipelined integer square root, one root bit per register stage.
module cpcr_isqrt (
	input  logic                            clk,
	input  logic                            en,
	input  logic [cpcr_pkg::SQ_IN_W-1:0]    rad,
	output logic [cpcr_pkg::SQ_ROOT_W-1:0]  root
);
	import cpcr_pkg::*;

	logic [SQ_REM_W-1:0]  rem_s [0:SQ_ROOT_W-1];
	logic [SQ_ROOT_W-1:0] acc_s [0:SQ_ROOT_W-1];

	for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_bit
		localparam int B = SQ_ROOT_W - 1 - k;
		logic [SQ_REM_W-1:0]  rem_in;
		logic [SQ_REM_W-1:0]  term;
		logic [SQ_ROOT_W-1:0] acc_in;

		if (k == 0) begin : g_first
			assign rem_in = SQ_REM_W'(rad);
			assign acc_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		// (r + 2^B)^2 - r^2
		assign term = (SQ_REM_W'(acc_in) << (B + 1)) + (SQ_REM_W'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= term) begin
					rem_s[k] <= rem_in - term;
					acc_s[k] <= acc_in | (SQ_ROOT_W'(1) << B);
				end else begin
					rem_s[k] <= rem_in;
					acc_s[k] <= acc_in;
				end
			end
		end
	end

	assign root = acc_s[SQ_ROOT_W-1];

endmodule

/* hdl/cpcr_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per register stage.
module cpcr_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [cpcr_pkg::DIV_NUM_W-1:0]  num,
	input  logic [cpcr_pkg::DIV_DEN_W-1:0]  den,
	output logic [cpcr_pkg::DIV_QUO_W-1:0]  quo
);
	import cpcr_pkg::*;

	logic [DIV_NUM_W-1:0] rem_s [0:DIV_QUO_W-1];
	logic [DIV_DEN_W-1:0] den_s [0:DIV_QUO_W-1];
	logic [DIV_QUO_W-1:0] quo_s [0:DIV_QUO_W-1];

	for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_bit
		localparam int B = DIV_QUO_W - 1 - k;
		logic [DIV_NUM_W-1:0] rem_in;
		logic [DIV_NUM_W-1:0] term;
		logic [DIV_DEN_W-1:0] den_in;
		logic [DIV_QUO_W-1:0] quo_in;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign term = DIV_NUM_W'(den_in) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				if (rem_in >= term) begin
					rem_s[k] <= rem_in - term;
					quo_s[k] <= quo_in | (DIV_QUO_W'(1) << B);
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_QUO_W-1];

endmodule

/* hdl/circle_pair_collision_response_core.sv */
// Top level: pipelined circle pair overlap test, separation and impulse.
//
// Input channel (in_valid/in_ready): one beat carries a circle pair (centres,
// velocities, radii, masses, restitutions), coordinates signed Q16.8 packed x:y.
// Output channel (out_valid/out_ready): one beat per input beat, in order,
// with the overlap flag, corrected centres, the impulse on B and a mass fault.
//
// Throughput: one beat per cycle while the receiver does not stall. Depth: 60
// register stages, which come mostly from the bit-per-stage square root
// (17 stages) followed by two chained bit-per-stage dividers (18 stages each:
// unit normal, then mass-weighted separation).
//
// Flow control: the whole pipe advances together. in_ready is high whenever the
// output stage is empty or being taken; when the receiver stalls with a result
// waiting, every stage holds and nothing is dropped or repeated.
//
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
// A zero mass flags mass_fault and returns the centres unchanged, zero impulse.
module circle_pair_collision_response_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [47:0] pos_a,
	input  logic [47:0] pos_b,
	input  logic [47:0] vel_a,
	input  logic [47:0] vel_b,
	input  logic [15:0] radius_a,
	input  logic [15:0] radius_b,
	input  logic [15:0] mass_a,
	input  logic [15:0] mass_b,
	input  logic [8:0]  bounce_a,
	input  logic [8:0]  bounce_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        collided,
	output logic [47:0] new_pos_a,
	output logic [47:0] new_pos_b,
	output logic [47:0] impulse_on_b,
	output logic        mass_fault
);
	import cpcr_pkg::*;

	// Per-item record carried down the pipe; fields fill in as stages compute them.
	typedef struct packed {
		logic                hit;
		logic                fault;
		logic                inr;
		logic                dxneg;
		logic                dyneg;
		logic [16:0]         adx;
		logic [16:0]         ady;
		logic [16:0]         rsum;
		logic [16:0]         len;
		logic [16:0]         depth;
		logic [16:0]         msum;
		logic [33:0]         sqx;
		logic [33:0]         sqy;
		logic [33:0]         sqr;
		logic [33:0]         d2;
		logic signed [24:0]  relx;
		logic signed [24:0]  rely;
		logic signed [23:0]  ax;
		logic signed [23:0]  ay;
		logic signed [23:0]  bx;
		logic signed [23:0]  by;
		logic [15:0]         ma;
		logic [15:0]         mb;
		logic [31:0]         mprod;
		logic [8:0]          e;
		logic [8:0]          nmx;
		logic [8:0]          nmy;
		logic [25:0]         pxd;
		logic [25:0]         pyd;
		logic signed [34:0]  dotx;
		logic signed [34:0]  doty;
		logic signed [35:0]  vsum;
		logic [33:0]         mxa;
		logic [33:0]         mxb;
		logic [33:0]         mya;
		logic [33:0]         myb;
		logic                vnneg;
		logic [27:0]         vnmag;
		logic [35:0]         tmag;
		logic [37:0]         jmag;
		logic [38:0]         ixm;
		logic [38:0]         iym;
		logic [23:0]         ix;
		logic [23:0]         iy;
	} item_t;

	// saturate a sign/magnitude value to the coordinate range
	function automatic logic [COORD_W-1:0] sat_mag(input logic neg, input logic [38:0] mag);
		if (!neg) begin
			return (mag > 39'(COORD_MAX)) ? COORD_W'(COORD_MAX) : mag[COORD_W-1:0];
		end
		if (mag > 39'(COORD_MAX) + 39'd1) begin
			return ~COORD_W'(COORD_MAX);
		end
		return (~mag[COORD_W-1:0]) + COORD_W'(1);
	endfunction

	// saturate a two-bit-wider signed sum to the coordinate range
	function automatic logic [COORD_W-1:0] sat_sum(input logic [COORD_W+1:0] v);
		if (v[COORD_W+1:COORD_W-1] == '0 || v[COORD_W+1:COORD_W-1] == '1) begin
			return v[COORD_W-1:0];
		end
		return v[COORD_W+1] ? ~COORD_W'(COORD_MAX) : COORD_W'(COORD_MAX);
	endfunction

	logic                  en;
	logic [PIPE_DEPTH:1]   vld_s;
	item_t                 it_s [1:PIPE_DEPTH-1];
	item_t                 it_d [1:PIPE_DEPTH-1];
	item_t                 fr;

	// front-end temporaries
	logic signed [24:0]    dx_c;
	logic signed [24:0]    dy_c;
	logic [24:0]           adx_c;
	logic [24:0]           ady_c;
	logic [8:0]            emin_c;
	logic signed [23:0]    avx_c;
	logic signed [23:0]    avy_c;
	logic signed [23:0]    bvx_c;
	logic signed [23:0]    bvy_c;

	// unit results
	logic [SQ_ROOT_W-1:0]  sq_root;
	logic [DIV_QUO_W-1:0]  nq_x;
	logic [DIV_QUO_W-1:0]  nq_y;
	logic [DIV_QUO_W-1:0]  mr_q;
	logic [DIV_QUO_W-1:0]  mq_ax;
	logic [DIV_QUO_W-1:0]  mq_ay;
	logic [DIV_QUO_W-1:0]  mq_bx;
	logic [DIV_QUO_W-1:0]  mq_by;

	// stage temporaries
	logic [34:0]           d2_sum;
	logic [8:0]            nmx_c;
	logic [8:0]            nmy_c;
	logic signed [9:0]     nxs_c;
	logic signed [9:0]     nys_c;
	logic [41:0]           prod_xa;
	logic [41:0]           prod_xb;
	logic [41:0]           prod_ya;
	logic [41:0]           prod_yb;
	logic [35:0]           abs_v;
	logic [43:0]           prod_t;
	logic [45:0]           prod_j;
	logic [46:0]           prod_ix;
	logic [46:0]           prod_iy;
	logic [COORD_W+1:0]    dqa_x;
	logic [COORD_W+1:0]    dqa_y;
	logic [COORD_W+1:0]    dqb_x;
	logic [COORD_W+1:0]    dqb_y;
	logic [COORD_W+1:0]    sum_ax;
	logic [COORD_W+1:0]    sum_ay;
	logic [COORD_W+1:0]    sum_bx;
	logic [COORD_W+1:0]    sum_by;
	logic                  act;

	// output stage
	logic                  collided_s60;
	logic                  mass_fault_s60;
	logic [47:0]           new_pos_a_s60;
	logic [47:0]           new_pos_b_s60;
	logic [47:0]           impulse_on_b_s60;

	// global advance: output empty or being taken
	assign en       = !vld_s[PIPE_DEPTH] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], in_valid};
		end
	end

	// ---- stage 1 inputs: deltas, bounding box pretest, mass terms ----
	always_comb begin
		fr       = '0;
		fr.ax    = pos_a[2*COORD_W-1:COORD_W];
		fr.ay    = pos_a[COORD_W-1:0];
		fr.bx    = pos_b[2*COORD_W-1:COORD_W];
		fr.by    = pos_b[COORD_W-1:0];
		avx_c    = vel_a[2*COORD_W-1:COORD_W];
		avy_c    = vel_a[COORD_W-1:0];
		bvx_c    = vel_b[2*COORD_W-1:COORD_W];
		bvy_c    = vel_b[COORD_W-1:0];
		dx_c     = {fr.ax[COORD_W-1], fr.ax} - {fr.bx[COORD_W-1], fr.bx};
		dy_c     = {fr.ay[COORD_W-1], fr.ay} - {fr.by[COORD_W-1], fr.by};
		adx_c    = dx_c[24] ? 25'(-dx_c) : 25'(dx_c);
		ady_c    = dy_c[24] ? 25'(-dy_c) : 25'(dy_c);
		fr.dxneg = dx_c[24];
		fr.dyneg = dy_c[24];
		fr.adx   = adx_c[16:0];
		fr.ady   = ady_c[16:0];
		fr.rsum  = 17'(radius_a) + 17'(radius_b);
		// squares are exact only inside this box; outside it there is no hit
		fr.inr   = (adx_c < 25'(fr.rsum)) && (ady_c < 25'(fr.rsum));
		fr.relx  = {bvx_c[COORD_W-1], bvx_c} - {avx_c[COORD_W-1], avx_c};
		fr.rely  = {bvy_c[COORD_W-1], bvy_c} - {avy_c[COORD_W-1], avy_c};
		fr.ma    = mass_a;
		fr.mb    = mass_b;
		fr.fault = (mass_a == '0) || (mass_b == '0);
		fr.mprod = 32'(mass_a) * 32'(mass_b);
		fr.msum  = 17'(mass_a) + 17'(mass_b);
		emin_c   = (bounce_a < bounce_b) ? bounce_a : bounce_b;
		fr.e     = (emin_c > 9'(ONE)) ? 9'(ONE) : emin_c;
	end

	assign d2_sum = 35'(it_s[2].sqx) + 35'(it_s[2].sqy);

	// unit normal magnitude; zero when centres coincide
	assign nmx_c = (it_s[ST_NRM-1].len == '0) ? '0 : nq_x[8:0];
	assign nmy_c = (it_s[ST_NRM-1].len == '0) ? '0 : nq_y[8:0];
	assign nxs_c = it_s[ST_NRM-1].dxneg ? -$signed({1'b0, nmx_c}) : $signed({1'b0, nmx_c});
	assign nys_c = it_s[ST_NRM-1].dyneg ? -$signed({1'b0, nmy_c}) : $signed({1'b0, nmy_c});

	assign prod_xa = 42'(it_s[ST_NRM].pxd) * 42'(it_s[ST_NRM].mb);
	assign prod_xb = 42'(it_s[ST_NRM].pxd) * 42'(it_s[ST_NRM].ma);
	assign prod_ya = 42'(it_s[ST_NRM].pyd) * 42'(it_s[ST_NRM].mb);
	assign prod_yb = 42'(it_s[ST_NRM].pyd) * 42'(it_s[ST_NRM].ma);

	assign abs_v   = it_s[ST_NRM+1].vsum[35] ? 36'(-it_s[ST_NRM+1].vsum)
	                                         : 36'(it_s[ST_NRM+1].vsum);
	assign prod_t  = 44'(it_s[ST_NRM+2].vnmag) * 44'(mr_q[15:0]);
	assign prod_j  = 46'(it_s[ST_NRM+3].tmag) * 46'(10'(ONE) + 10'(it_s[ST_NRM+3].e));
	assign prod_ix = 47'(it_s[ST_NRM+4].jmag) * 47'(it_s[ST_NRM+4].nmx);
	assign prod_iy = 47'(it_s[ST_NRM+4].jmag) * 47'(it_s[ST_NRM+4].nmy);

	// ---- payload pipe: next record for every stage ----
	always_comb begin
		it_d[1] = fr;
		for (int k = 2; k < PIPE_DEPTH; k++) begin
			it_d[k] = it_s[k-1];
		end
		// squares
		it_d[2].sqx = 34'(it_s[1].adx) * 34'(it_s[1].adx);
		it_d[2].sqy = 34'(it_s[1].ady) * 34'(it_s[1].ady);
		it_d[2].sqr = 34'(it_s[1].rsum) * 34'(it_s[1].rsum);
		// overlap test
		it_d[ST_SQRT_IN].d2  = d2_sum[33:0];
		it_d[ST_SQRT_IN].hit = it_s[2].inr && (d2_sum < 35'(it_s[2].sqr));
		// centre distance and penetration depth
		it_d[ST_NDIV_IN].len   = sq_root;
		it_d[ST_NDIV_IN].depth = it_s[ST_NDIV_IN-1].rsum - sq_root;
		// normal, separation numerators, normal velocity terms
		it_d[ST_NRM].nmx  = nmx_c;
		it_d[ST_NRM].nmy  = nmy_c;
		it_d[ST_NRM].pxd  = 26'(nmx_c) * 26'(it_s[ST_NRM-1].depth);
		it_d[ST_NRM].pyd  = 26'(nmy_c) * 26'(it_s[ST_NRM-1].depth);
		it_d[ST_NRM].dotx = 35'(it_s[ST_NRM-1].relx) * 35'(nxs_c);
		it_d[ST_NRM].doty = 35'(it_s[ST_NRM-1].rely) * 35'(nys_c);
		// mass weighting (the /2^F of the separation folded in here)
		it_d[ST_MDIV_IN].mxa  = prod_xa[41:FRAC_BITS];
		it_d[ST_MDIV_IN].mxb  = prod_xb[41:FRAC_BITS];
		it_d[ST_MDIV_IN].mya  = prod_ya[41:FRAC_BITS];
		it_d[ST_MDIV_IN].myb  = prod_yb[41:FRAC_BITS];
		it_d[ST_MDIV_IN].vsum = 36'(it_s[ST_NRM].dotx) + 36'(it_s[ST_NRM].doty);
		// impulse chain in sign/magnitude, truncating toward zero
		it_d[ST_NRM+2].vnneg = it_s[ST_NRM+1].vsum[35];
		it_d[ST_NRM+2].vnmag = abs_v[35:FRAC_BITS];
		it_d[ST_NRM+3].tmag  = prod_t[43:FRAC_BITS];
		it_d[ST_NRM+4].jmag  = prod_j[45:FRAC_BITS];
		it_d[ST_NRM+5].ixm   = prod_ix[46:FRAC_BITS];
		it_d[ST_NRM+5].iym   = prod_iy[46:FRAC_BITS];
		// j has the opposite sign of vn
		it_d[ST_NRM+6].ix = sat_mag(!it_s[ST_NRM+5].vnneg ^ it_s[ST_NRM+5].dxneg,
			it_s[ST_NRM+5].ixm);
		it_d[ST_NRM+6].iy = sat_mag(!it_s[ST_NRM+5].vnneg ^ it_s[ST_NRM+5].dyneg,
			it_s[ST_NRM+5].iym);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				it_s[k] <= it_d[k];
			end
		end
	end

	// ---- arithmetic units ----
	cpcr_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (it_s[ST_SQRT_IN].d2),
		.root (sq_root)
	);

	cpcr_div u_div_nx (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(it_s[ST_NDIV_IN].adx) << FRAC_BITS),
		.den (it_s[ST_NDIV_IN].len),
		.quo (nq_x)
	);

	cpcr_div u_div_ny (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(it_s[ST_NDIV_IN].ady) << FRAC_BITS),
		.den (it_s[ST_NDIV_IN].len),
		.quo (nq_y)
	);

	// reduced mass, timed to land beside vn
	cpcr_div u_div_mr (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(it_s[ST_MR_IN].mprod)),
		.den (it_s[ST_MR_IN].msum),
		.quo (mr_q)
	);

	cpcr_div u_div_ax (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(it_s[ST_MDIV_IN].mxa)),
		.den (it_s[ST_MDIV_IN].msum),
		.quo (mq_ax)
	);

	cpcr_div u_div_ay (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(it_s[ST_MDIV_IN].mya)),
		.den (it_s[ST_MDIV_IN].msum),
		.quo (mq_ay)
	);

	cpcr_div u_div_bx (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(it_s[ST_MDIV_IN].mxb)),
		.den (it_s[ST_MDIV_IN].msum),
		.quo (mq_bx)
	);

	cpcr_div u_div_by (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(it_s[ST_MDIV_IN].myb)),
		.den (it_s[ST_MDIV_IN].msum),
		.quo (mq_by)
	);

	// ---- final stage: apply separation, select unchanged outputs when idle ----
	assign act    = it_s[PIPE_DEPTH-1].hit && !it_s[PIPE_DEPTH-1].fault;
	assign dqa_x  = it_s[PIPE_DEPTH-1].dxneg ? -(COORD_W+2)'(mq_ax) : (COORD_W+2)'(mq_ax);
	assign dqa_y  = it_s[PIPE_DEPTH-1].dyneg ? -(COORD_W+2)'(mq_ay) : (COORD_W+2)'(mq_ay);
	assign dqb_x  = it_s[PIPE_DEPTH-1].dxneg ? -(COORD_W+2)'(mq_bx) : (COORD_W+2)'(mq_bx);
	assign dqb_y  = it_s[PIPE_DEPTH-1].dyneg ? -(COORD_W+2)'(mq_by) : (COORD_W+2)'(mq_by);
	assign sum_ax = (COORD_W+2)'(it_s[PIPE_DEPTH-1].ax) + dqa_x;
	assign sum_ay = (COORD_W+2)'(it_s[PIPE_DEPTH-1].ay) + dqa_y;
	assign sum_bx = (COORD_W+2)'(it_s[PIPE_DEPTH-1].bx) - dqb_x;
	assign sum_by = (COORD_W+2)'(it_s[PIPE_DEPTH-1].by) - dqb_y;

	always_ff @(posedge clk) begin
		if (en) begin
			collided_s60   <= it_s[PIPE_DEPTH-1].hit;
			mass_fault_s60 <= it_s[PIPE_DEPTH-1].fault;
			if (act) begin
				new_pos_a_s60    <= {sat_sum(sum_ax), sat_sum(sum_ay)};
				new_pos_b_s60    <= {sat_sum(sum_bx), sat_sum(sum_by)};
				impulse_on_b_s60 <= {it_s[PIPE_DEPTH-1].ix, it_s[PIPE_DEPTH-1].iy};
			end else begin
				new_pos_a_s60    <= {it_s[PIPE_DEPTH-1].ax, it_s[PIPE_DEPTH-1].ay};
				new_pos_b_s60    <= {it_s[PIPE_DEPTH-1].bx, it_s[PIPE_DEPTH-1].by};
				impulse_on_b_s60 <= '0;
			end
		end
	end

	assign out_valid    = vld_s[PIPE_DEPTH];
	assign collided     = collided_s60;
	assign mass_fault   = mass_fault_s60;
	assign new_pos_a    = new_pos_a_s60;
	assign new_pos_b    = new_pos_b_s60;
	assign impulse_on_b = impulse_on_b_s60;

endmodule
